FILE: hdl/embs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package embs_pkg;

   // Image and light geometry.
   localparam int ENV_SIDE     = 128;
   localparam int COORD_W      = $clog2(ENV_SIDE);
   localparam int ENV_ADDR_W   = 2 * COORD_W;
   localparam int ENV_DEPTH    = ENV_SIDE * ENV_SIDE;
   localparam int COORD_MAX    = ENV_SIDE - 1;
   localparam int LIGHT_RADIUS = 128;
   localparam int RADIUS_SQ    = LIGHT_RADIUS * LIGHT_RADIUS;

   // Field widths.
   localparam int X_W     = 9;
   localparam int Y_W     = 8;
   localparam int PIX_W   = 8;
   localparam int GRAD_W  = 9;
   localparam int SUM_W   = 11;
   localparam int SQX_W   = 2 * X_W;
   localparam int SQY_W   = 2 * Y_W;
   localparam int DSQ_W   = SQX_W + 1;
   localparam int IDX_W   = 14;

   // Stream and register port widths.
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Item kinds carried in req_tuser.
   localparam logic OP_SHADE = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_Y = 2'd1;

   // Register reset values.
   localparam logic [X_W-1:0] LIGHT_X_RESET = 9'd160;
   localparam logic [Y_W-1:0] LIGHT_Y_RESET = 8'd100;

   // First stage: gradients and distances.
   typedef struct packed {
      logic                     op;
      logic [X_W-1:0]           px;
      logic [Y_W-1:0]           py;
      logic [PIX_W-1:0]         bg;
      logic signed [GRAD_W-1:0] grad_x;
      logic signed [GRAD_W-1:0] grad_y;
      logic [X_W-1:0]           dx;
      logic [Y_W-1:0]           dy;
      logic [IDX_W-1:0]         tidx;
      logic [PIX_W-1:0]         tval;
   } stage1_type;

   // Second stage: squared distances and the table address.
   typedef struct packed {
      logic                  op;
      logic [X_W-1:0]        px;
      logic [Y_W-1:0]        py;
      logic [PIX_W-1:0]      bg;
      logic [SQX_W-1:0]      dsq_x;
      logic [SQY_W-1:0]      dsq_y;
      logic [ENV_ADDR_W-1:0] addr;
      logic [PIX_W-1:0]      tval;
   } stage2_type;

   // Third stage: lines up with the table read data.
   typedef struct packed {
      logic [X_W-1:0]   px;
      logic [Y_W-1:0]   py;
      logic [PIX_W-1:0] bg;
      logic             in_radius;
   } stage3_type;

   // Clamp gradient plus distance into a table coordinate.
   function automatic logic [COORD_W-1:0] env_coord(
      input logic signed [GRAD_W-1:0] grad,
      input logic [X_W-1:0]           distance
   );
      logic signed [SUM_W-1:0] c;
      logic [COORD_W-1:0]      r;
      c = SUM_W'(grad) + $signed({2'b00, distance});
      if (c < 0) begin
         r = '0;
      end else if (c > COORD_MAX) begin
         r = COORD_W'(COORD_MAX);
      end else begin
         r = c[COORD_W-1:0];
      end
      // Distances at the table edge always map to the first column or row.
      if (distance >= X_W'(COORD_MAX)) begin
         r = '0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/env_mapped_bump_shader.sv
`timescale 1ns / 1ps
`default_nettype none

// Environment-mapped bump shader. Each shade transfer on req_ (tuser low) gives one
// result transfer on rsp_ with the shaded palette index; each table-write transfer
// (tuser high) loads one byte of the 128x128 environment table and gives no result.
// The block takes one item per clock unless the result stream stalls; each shade item
// passes through the stages into the output register. The pipeline is gradient/distance,
// square/address, table access, color. Writes and reads share the single port of the
// 16384 x 8 table in the table-access stage, so all items act on the table in their
// arrival order. The table is not cleared by reset: load every entry a shade item
// can reach before shading. Write light_x and light_y only while the block is idle.
module env_mapped_bump_shader (
   input  wire                                   clock,
   input  wire                                   reset,
   // Input stream.
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0 up: pix_x, pix_y, background, height_left, height_right,
   // height_up, height_down, table_index, table_value, one zero pad bit.
   input  wire  [embs_pkg::REQ_DATA_W-1:0]       req_tdata,
   // Fields from bit 0 up: op.
   input  wire                                   req_tuser,
   // Result stream.
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // Fields from bit 0 up: out_x, out_y, color, seven zero pad bits.
   output logic [embs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // Register writes.
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [embs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [embs_pkg::CSR_DATA_W-1:0]       csr_data
);

   // Light position registers.
   logic [embs_pkg::X_W-1:0] light_x_ff;
   logic [embs_pkg::Y_W-1:0] light_y_ff;

   // Pipeline stages.
   embs_pkg::stage1_type s1_ff, s1_in;
   embs_pkg::stage2_type s2_ff, s2_in;
   embs_pkg::stage3_type s3_ff, s3_in;
   logic v1_ff, v2_ff, v3_ff;
   logic ready1, ready2, ready3, out_ready;

   // Environment table and its read register.
   logic [embs_pkg::PIX_W-1:0] env_mem [embs_pkg::ENV_DEPTH];
   logic [embs_pkg::PIX_W-1:0] mem_q_ff;
   logic                       mem_en;
   logic                       mem_we;

   // Output register.
   logic                             rsp_valid_ff;
   logic [embs_pkg::X_W-1:0]         rsp_x_ff, rsp_x_in;
   logic [embs_pkg::Y_W-1:0]         rsp_y_ff, rsp_y_in;
   logic [embs_pkg::PIX_W-1:0]       rsp_color_ff, rsp_color_in;
   logic                             out_load;

   // Unpacked input fields.
   logic [embs_pkg::X_W-1:0]   in_px;
   logic [embs_pkg::Y_W-1:0]   in_py;
   logic [embs_pkg::PIX_W-1:0] in_bg, in_hl, in_hr, in_hu, in_hd, in_tval;
   logic [embs_pkg::IDX_W-1:0] in_tidx;

   logic [embs_pkg::DSQ_W-1:0]   dist_sq;
   logic [embs_pkg::COORD_W-1:0] cx, cy;

   assign in_px   = req_tdata[8:0];
   assign in_py   = req_tdata[16:9];
   assign in_bg   = req_tdata[24:17];
   assign in_hl   = req_tdata[32:25];
   assign in_hr   = req_tdata[40:33];
   assign in_hu   = req_tdata[48:41];
   assign in_hd   = req_tdata[56:49];
   assign in_tidx = req_tdata[70:57];
   assign in_tval = req_tdata[78:71];

   // Each stage moves on when it is empty or the one after it moves.
   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign ready3     = !v3_ff || out_ready;
   assign ready2     = !v2_ff || ready3;
   assign ready1     = !v1_ff || ready2;
   assign req_tready = ready1;
   assign csr_ready  = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= embs_pkg::LIGHT_X_RESET;
         light_y_ff <= embs_pkg::LIGHT_Y_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            embs_pkg::REG_LIGHT_X: light_x_ff <= csr_data;
            embs_pkg::REG_LIGHT_Y: light_y_ff <= csr_data[embs_pkg::Y_W-1:0];
            default: ;
         endcase
      end
   end

   // Stage 1: gradients and distances to the light.
   always_comb begin
      s1_in.op     = req_tuser;
      s1_in.px     = in_px;
      s1_in.py     = in_py;
      s1_in.bg     = in_bg;
      s1_in.grad_x = $signed({1'b0, in_hr}) - $signed({1'b0, in_hl});
      s1_in.grad_y = $signed({1'b0, in_hd}) - $signed({1'b0, in_hu});
      s1_in.dx     = (in_px >= light_x_ff) ? in_px - light_x_ff : light_x_ff - in_px;
      s1_in.dy     = (in_py >= light_y_ff) ? in_py - light_y_ff : light_y_ff - in_py;
      s1_in.tidx   = in_tidx;
      s1_in.tval   = in_tval;
   end

   // Stage 2: squared distances and table coordinates.
   always_comb begin
      cx           = embs_pkg::env_coord(s1_ff.grad_x, s1_ff.dx);
      cy           = embs_pkg::env_coord(s1_ff.grad_y, {1'b0, s1_ff.dy});
      s2_in.op     = s1_ff.op;
      s2_in.px     = s1_ff.px;
      s2_in.py     = s1_ff.py;
      s2_in.bg     = s1_ff.bg;
      s2_in.dsq_x  = embs_pkg::SQX_W'(s1_ff.dx) * embs_pkg::SQX_W'(s1_ff.dx);
      s2_in.dsq_y  = embs_pkg::SQY_W'(s1_ff.dy) * embs_pkg::SQY_W'(s1_ff.dy);
      s2_in.addr   = (s1_ff.op == embs_pkg::OP_WRITE) ? s1_ff.tidx : {cy, cx};
      s2_in.tval   = s1_ff.tval;
   end

   // Stage 3: radius test alongside the table access.
   always_comb begin
      dist_sq         = embs_pkg::DSQ_W'(s2_ff.dsq_x) + embs_pkg::DSQ_W'(s2_ff.dsq_y);
      s3_in.px        = s2_ff.px;
      s3_in.py        = s2_ff.py;
      s3_in.bg        = s2_ff.bg;
      s3_in.in_radius = dist_sq <= embs_pkg::DSQ_W'(embs_pkg::RADIUS_SQ);
   end

   assign mem_en = v2_ff && ready3;
   assign mem_we = s2_ff.op == embs_pkg::OP_WRITE;

   // Single-port table: a write item writes, a shade item reads.
   always_ff @(posedge clock) begin
      if (mem_en) begin
         if (mem_we) begin
            env_mem[s2_ff.addr] <= s2_ff.tval;
         end else begin
            mem_q_ff <= env_mem[s2_ff.addr];
         end
      end
   end

   // Color: background plus half the table value inside the radius.
   always_comb begin
      rsp_x_in     = s3_ff.px;
      rsp_y_in     = s3_ff.py;
      rsp_color_in = s3_ff.in_radius ? s3_ff.bg + {1'b0, mem_q_ff[embs_pkg::PIX_W-1:1]}
                                     : s3_ff.bg;
   end

   assign out_load = v3_ff && out_ready;

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= req_tvalid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         // Write items end at the table and do not go on.
         if (ready3) begin
            v3_ff <= v2_ff && (s2_ff.op == embs_pkg::OP_SHADE);
         end
         if (out_ready) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   // Pipeline payload.
   always_ff @(posedge clock) begin
      if (ready1) begin
         s1_ff <= s1_in;
      end
      if (ready2) begin
         s2_ff <= s2_in;
      end
      if (ready3) begin
         s3_ff <= s3_in;
      end
      if (out_load) begin
         rsp_x_ff     <= rsp_x_in;
         rsp_y_ff     <= rsp_y_in;
         rsp_color_ff <= rsp_color_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_color_ff, rsp_y_ff, rsp_x_ff};

   // The input stalls only when every stage holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff))
      else $error("input stalled with a free pipeline stage");

   // The table is not accessed while its stage is held.
   assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !ready3) |-> !mem_en)
      else $error("table accessed during a stall");

   // Outside the radius the background passes through.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && !s3_ff.in_radius) |=> (rsp_color_ff == $past(s3_ff.bg)))
      else $error("background altered outside the light radius");

   // A write item never turns into a result.
   assert property (@(posedge clock) disable iff (reset)
      (v2_ff && ready3 && (s2_ff.op == embs_pkg::OP_WRITE)) |=> !v3_ff)
      else $error("table write produced a result");

endmodule

`default_nettype wire

FILE: test/env_mapped_bump_shader_tb.sv
`timescale 1ns / 1ps

module env_mapped_bump_shader_tb;
   import embs_pkg::*;

   // Register indexes that select no register.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_3 = 2'd3;

   // Cycles to let writes still in the pipeline settle.
   localparam int SETTLE_CYCLES = 12;
   localparam int ITEMS_PER_PHASE = 132;

   typedef struct {
      logic             op;
      logic [X_W-1:0]   pix_x;
      logic [Y_W-1:0]   pix_y;
      logic [PIX_W-1:0] background;
      logic [PIX_W-1:0] height_left;
      logic [PIX_W-1:0] height_right;
      logic [PIX_W-1:0] height_up;
      logic [PIX_W-1:0] height_down;
      logic [IDX_W-1:0] table_index;
      logic [PIX_W-1:0] table_value;
   } pixel_req_type;

   typedef struct {
      logic [X_W-1:0]   out_x;
      logic [Y_W-1:0]   out_y;
      logic [PIX_W-1:0] color;
   } shaded_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Shadow copies of the light registers and the environment table.
   logic [X_W-1:0]   light_x_q = LIGHT_X_RESET;
   logic [Y_W-1:0]   light_y_q = LIGHT_Y_RESET;
   logic [PIX_W-1:0] env_shadow [0:ENV_DEPTH-1];
   // Entries that some queued write item loads before any shade item reads them.
   bit               env_loaded [0:ENV_DEPTH-1];

   pixel_req_type    pending_items[$];
   shaded_pixel_type expected_pixels[$];
   pixel_req_type    on_wire;

   int  error_count = 0;
   int  results_seen = 0;
   int  long_hold_left = 0;
   bit  long_hold_done = 1'b0;
   int  src_gap = 0;
   int  src_calm = 0;
   int  snk_gap = 0;
   int  snk_calm = 0;

   env_mapped_bump_shader DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp gradient plus distance to a table coordinate; far distances map to zero.
   function automatic int table_coord(input int grad, input int distance);
      int c;
      c = grad + distance;
      if (c < 0) c = 0;
      if (c > ENV_SIDE - 1) c = ENV_SIDE - 1;
      if (distance >= ENV_SIDE - 1) c = 0;
      return c;
   endfunction

   // Table address that a shade item reads, or -1 when it lies outside the radius.
   function automatic int shade_addr(input pixel_req_type it);
      int dx, dy, cx, cy;
      dx = (int'(it.pix_x) > int'(light_x_q)) ? int'(it.pix_x) - int'(light_x_q)
                                              : int'(light_x_q) - int'(it.pix_x);
      dy = (int'(it.pix_y) > int'(light_y_q)) ? int'(it.pix_y) - int'(light_y_q)
                                              : int'(light_y_q) - int'(it.pix_y);
      if (dx * dx + dy * dy > RADIUS_SQ) return -1;
      cx = table_coord(int'(it.height_right) - int'(it.height_left), dx);
      cy = table_coord(int'(it.height_down) - int'(it.height_up), dy);
      return cx + ENV_SIDE * cy;
   endfunction

   // Expected result of one shade item against the current shadow state.
   function automatic shaded_pixel_type shade_pixel(input pixel_req_type it);
      shaded_pixel_type p;
      int addr, sum;
      addr = shade_addr(it);
      sum = int'(it.background);
      if (addr >= 0) begin
         sum = sum + int'(env_shadow[addr]) / 2;
      end
      p.out_x = it.pix_x;
      p.out_y = it.pix_y;
      p.color = sum[PIX_W-1:0];
      return p;
   endfunction

   function automatic pixel_req_type shade_item(input int px, input int py, input int bg,
                                                input int hl, input int hr,
                                                input int hu, input int hd);
      pixel_req_type it;
      it.op           = OP_SHADE;
      it.pix_x        = px[X_W-1:0];
      it.pix_y        = py[Y_W-1:0];
      it.background   = bg[PIX_W-1:0];
      it.height_left  = hl[PIX_W-1:0];
      it.height_right = hr[PIX_W-1:0];
      it.height_up    = hu[PIX_W-1:0];
      it.height_down  = hd[PIX_W-1:0];
      it.table_index  = IDX_W'($urandom);
      it.table_value  = PIX_W'($urandom);
      return it;
   endfunction

   function automatic pixel_req_type table_write(input int idx, input int val);
      pixel_req_type it;
      it = shade_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      it.op          = OP_WRITE;
      it.table_index = idx[IDX_W-1:0];
      it.table_value = val[PIX_W-1:0];
      return it;
   endfunction

   // A position within reach of the light, folded back into 0..max_pos.
   function automatic int near_light(input int center, input int max_pos);
      int v;
      v = center + int'($urandom_range(0, 272)) - 136;
      if (v < 0) v = -v;
      if (v > max_pos) v = 2 * max_pos - v;
      return v;
   endfunction

   function automatic pixel_req_type random_item();
      pixel_req_type it;
      int r, hl, hu;
      r = $urandom_range(0, 99);
      hl = $urandom_range(0, 255);
      hu = $urandom_range(0, 255);
      if (r < 10) begin
         it = table_write($urandom, $urandom);
      end else if (r < 15) begin
         it = shade_item($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
      end else if (r < 55) begin
         // Neighboring heights close together keep the coordinates off the clamps.
         it = shade_item(near_light(int'(light_x_q), 511), near_light(int'(light_y_q), 255),
                         $urandom, hl, hl ^ $urandom_range(0, 31),
                         hu, hu ^ $urandom_range(0, 31));
      end else begin
         it = shade_item(near_light(int'(light_x_q), 511), near_light(int'(light_y_q), 255),
                         $urandom, hl, $urandom, hu, $urandom);
      end
      return it;
   endfunction

   // Queue one item; a shade item that would read a fresh entry gets a write to it first.
   task automatic push_item(input pixel_req_type it);
      int addr;
      if (it.op == OP_WRITE) begin
         env_loaded[it.table_index] = 1'b1;
      end else begin
         addr = shade_addr(it);
         if (addr >= 0 && !env_loaded[addr]) begin
            pending_items.push_back(table_write(addr, $urandom));
            env_loaded[addr] = 1'b1;
         end
      end
      pending_items.push_back(it);
   endtask

   // Idle length: mostly short, now and then long.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(1, 2);
      if (r < 92) return $urandom_range(3, 8);
      return $urandom_range(15, 30);
   endfunction

   // Input driver; each accepted transfer updates the shadow state or adds an expectation.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap = 0;
         src_calm = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (on_wire.op == OP_WRITE) begin
               env_shadow[on_wire.table_index] = on_wire.table_value;
            end else begin
               expected_pixels.push_back(shade_pixel(on_wire));
            end
         end
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               on_wire = pending_items.pop_front();
               req_tdata <= {1'b0, on_wire.table_value, on_wire.table_index,
                             on_wire.height_down, on_wire.height_up,
                             on_wire.height_right, on_wire.height_left,
                             on_wire.background, on_wire.pix_y, on_wire.pix_x};
               req_tuser <= on_wire.op;
               req_tvalid <= 1'b1;
               if (src_calm > 0) begin
                  src_calm--;
               end else if ($urandom_range(0, 99) < 2) begin
                  src_calm = $urandom_range(40, 120);
               end else if ($urandom_range(0, 99) < 30) begin
                  src_gap = idle_length();
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // One long hold-off of the receiver so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         long_hold_left <= 0;
         long_hold_done <= 1'b0;
      end else if (!long_hold_done && results_seen >= 40) begin
         long_hold_left <= 400;
         long_hold_done <= 1'b1;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // Receiver ready with random stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         snk_gap = 0;
         snk_calm = 0;
      end else if (long_hold_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (snk_gap > 0) begin
         snk_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (snk_calm > 0) begin
            snk_calm--;
         end else if ($urandom_range(0, 99) < 1) begin
            snk_calm = $urandom_range(40, 120);
         end else if ($urandom_range(0, 99) < 15) begin
            snk_gap = idle_length();
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // Result monitor: each transfer is checked against the oldest expectation.
   always @(posedge clock) begin
      shaded_pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         if (expected_pixels.size() == 0) begin
            error_count++;
            $display("%0t ns: result with none expected, got x=%0d y=%0d color=%0d",
                     $time, rsp_tdata[X_W-1:0], rsp_tdata[X_W+Y_W-1:X_W],
                     rsp_tdata[X_W+Y_W+PIX_W-1:X_W+Y_W]);
         end else begin
            want = expected_pixels.pop_front();
            check_field("out_x", want.out_x, rsp_tdata[X_W-1:0]);
            check_field("out_y", want.out_y, rsp_tdata[X_W+Y_W-1:X_W]);
            check_field("color", want.color, rsp_tdata[X_W+Y_W+PIX_W-1:X_W+Y_W]);
         end
      end
   end

   // Wait until the block is idle, including writes that give no result.
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_LIGHT_X: light_x_q = val;
         REG_LIGHT_Y: light_y_q = val[Y_W-1:0];
         default: ;
      endcase
   endtask

   task automatic random_phase();
      while (pending_items.size() < ITEMS_PER_PHASE) push_item(random_item());
      wait_idle();
   endtask

   // Stimulus sequence.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed items around the reset light position of 160, 100. Every entry a
      // shade item reads gets a write ahead of it.
      push_item(table_write(0, 255));
      // Color wraps past 255.
      push_item(shade_item(160, 100, 255, 0, 0, 0, 0));
      push_item(table_write(ENV_DEPTH - 1, 0));
      // Both gradients clamp high and read the last entry.
      push_item(shade_item(160, 100, 0, 0, 255, 0, 255));
      push_item(table_write(ENV_DEPTH - 1, 255));
      push_item(shade_item(160, 100, 0, 0, 255, 0, 255));
      // Both gradients clamp low.
      push_item(shade_item(160, 100, 128, 255, 0, 255, 0));
      // Distance equal to the radius counts as inside.
      push_item(shade_item(288, 100, $urandom, 0, 40, 0, 3));
      push_item(shade_item(32, 100, $urandom, 9, 0, 20, 30));
      push_item(shade_item(160, 228, $urandom, 0, 5, 0, 0));
      // Just past the radius.
      push_item(shade_item(288, 101, 77, 0, 40, 0, 3));
      // Distance at the table edge forces the coordinate to zero.
      push_item(shade_item(160, 227, $urandom, 0, 0, 0, 50));
      push_item(shade_item(33, 100, $urandom, 0, 60, 0, 0));
      // One short of the table edge: exact fit and clamp.
      push_item(shade_item(286, 100, $urandom, 10, 11, 4, 4));
      push_item(shade_item(286, 100, $urandom, 10, 12, 4, 2));
      // Diagonal just inside and just outside.
      push_item(shade_item(251, 190, $urandom, 3, 8, 8, 3));
      push_item(shade_item(251, 191, $urandom, 3, 8, 8, 3));
      // Positions at the ends of their fields.
      push_item(shade_item(511, 255, 200, 255, 255, 255, 255));
      push_item(shade_item(0, 0, 0, 0, 0, 0, 0));
      push_item(shade_item(319, 199, $urandom, $urandom, $urandom, $urandom, $urandom));
      wait_idle();

      random_phase();

      write_register(REG_LIGHT_X, 9'd0);
      write_register(REG_LIGHT_Y, 9'd0);
      random_phase();

      // Bit 8 of the data is dropped for light_y.
      write_register(REG_LIGHT_X, 9'h1FF);
      write_register(REG_LIGHT_Y, 9'h1FF);
      random_phase();

      write_register(REG_LIGHT_X, 9'd319);
      write_register(REG_LIGHT_Y, 9'd199);
      write_register(REG_SPARE_2, CSR_DATA_W'($urandom));
      write_register(REG_SPARE_3, CSR_DATA_W'($urandom));
      random_phase();

      write_register(REG_LIGHT_X, CSR_DATA_W'($urandom));
      write_register(REG_LIGHT_Y, CSR_DATA_W'($urandom));
      random_phase();

      if (error_count == 0) begin
         $display("env_mapped_bump_shader: match");
      end else begin
         $display("env_mapped_bump_shader: mismatch");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #30_000_000;
      $display("env_mapped_bump_shader: mismatch");
      $finish;
   end

endmodule
